// ----- design/ptw_pkg.sv -----
// ptw_pkg: shared types and codes for the two-level page table walker
// no dependencies; used by ptw_walk_step, two_level_page_table_walker, walk_checker and tb

package ptw_pkg;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    // fault codes
    localparam logic FAULT_INVALID = 1'b0;
    localparam logic FAULT_DEEP    = 1'b1;

    // request function codes
    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_PTE_RESP  = 1'b1;

    // field widths
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PPN_W  = 22;

    // walk state carried between requests
    typedef struct packed {
        logic              busy;
        logic              level;
        logic [ADDR_W-1:0] vaddr;
    } ptw_state_t;

    // one result of the walk
    typedef struct packed {
        logic              emit;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] phys_addr;
        logic              fault_code;
    } ptw_result_t;

endpackage

// ----- design/ptw_req_if.sv -----
// ptw_req_if: request channel of the page table walker
// depends on nothing

interface ptw_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] virt_addr;
    logic [31:0] pte_word;

    modport source (output valid, output func, output virt_addr, output pte_word, input ready);
    modport sink (input valid, input func, input virt_addr, input pte_word, output ready);
endinterface

// ----- design/ptw_rsp_if.sv -----
// ptw_rsp_if: result channel of the page table walker
// depends on nothing

interface ptw_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] phys_addr;
    logic        fault_code;

    modport source (output valid, output kind, output phys_addr, output fault_code, input ready);
    modport sink (input valid, input kind, input phys_addr, input fault_code, output ready);
endinterface

// ----- design/ptw_walk_step.sv -----
// ptw_walk_step: one step of the walk, combinational
// depends on ptw_pkg for state, result types and codes

module ptw_walk_step (
    input  logic                        func,
    input  logic [31:0]                 virt_addr,
    input  logic [31:0]                 pte_word,
    input  logic [ptw_pkg::PPN_W-1:0]   root_ppn,
    input  ptw_pkg::ptw_state_t         state,
    output ptw_pkg::ptw_state_t         state_next,
    output ptw_pkg::ptw_result_t        result
);

    logic [9:0]  vpn1;
    logic [9:0]  vpn0_saved;
    logic [11:0] off_saved;
    logic        pte_v;
    logic        pte_leaf;

    assign vpn1       = virt_addr[31:22];
    assign vpn0_saved = state.vaddr[21:12];
    assign off_saved  = state.vaddr[11:0];
    assign pte_v      = pte_word[0];
    assign pte_leaf   = pte_word[1] | pte_word[3];

    // decode request against walk state
    always_comb
    begin
        state_next        = state;
        result.emit       = 1'b0;
        result.kind       = ptw_pkg::KIND_READ;
        result.phys_addr  = '0;
        result.fault_code = ptw_pkg::FAULT_INVALID;
        if (func == ptw_pkg::FUNC_TRANSLATE)
        begin
            // new translation: read level-1 entry
            if (!state.busy)
            begin
                state_next.busy  = 1'b1;
                state_next.level = 1'b1;
                state_next.vaddr = virt_addr;
                result.emit      = 1'b1;
                result.kind      = ptw_pkg::KIND_READ;
                result.phys_addr = {root_ppn[19:0], vpn1, 2'b00};
            end
        end
        else if (state.busy)
        begin
            result.emit = 1'b1;
            if (!pte_v)
            begin
                // invalid entry
                state_next.busy   = 1'b0;
                state_next.level  = 1'b1;
                result.kind       = ptw_pkg::KIND_FAULT;
                result.fault_code = ptw_pkg::FAULT_INVALID;
            end
            else if (pte_leaf)
            begin
                // leaf: superpage at level 1, page at level 0
                state_next.busy  = 1'b0;
                state_next.level = 1'b1;
                result.kind      = ptw_pkg::KIND_DONE;
                if (state.level)
                    result.phys_addr = {pte_word[29:20], vpn0_saved, off_saved};
                else
                    result.phys_addr = {pte_word[29:10], off_saved};
            end
            else if (state.level)
            begin
                // pointer at level 1: read level-0 entry
                state_next.level = 1'b0;
                result.kind      = ptw_pkg::KIND_READ;
                result.phys_addr = {pte_word[29:10], vpn0_saved, 2'b00};
            end
            else
            begin
                // pointer at level 0
                state_next.busy   = 1'b0;
                state_next.level  = 1'b1;
                result.kind       = ptw_pkg::KIND_FAULT;
                result.fault_code = ptw_pkg::FAULT_DEEP;
            end
        end
    end

endmodule

// ----- design/two_level_page_table_walker.sv -----
// two_level_page_table_walker: top level of the two-level page table walker
// depends on ptw_pkg, ptw_req_if, ptw_rsp_if and ptw_walk_step
//
// Usage:
//   req carries both translation requests (func 0, virt_addr) and entry
//   read responses (func 1, pte_word). rsp carries one result per request
//   that produces one: an entry read request, a finished translation or a
//   page fault. A translation request while a walk is in flight, or a
//   response while idle, is taken and dropped without a result.
//   root_ppn is written through cfg_wr_en / cfg_wr_data; the user must
//   do so only while the walker is idle, the block does not enforce it.
//   Pipeline: a request is held in an input register, then its result
//   sits in the output register that drives rsp.valid.
//   Throughput: one request per cycle while rsp is not stalled, set by the
//   single pass of decode logic between the input and output registers.
//   Stall: while rsp is stalled with a result held, the input register
//   still takes a request if it is empty, then req.ready drops.
//   Reset: no walk in flight, level 1, root_ppn 0, both registers empty.

module two_level_page_table_walker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [ptw_pkg::PPN_W-1:0] cfg_wr_data,
    ptw_req_if.sink                   req,
    ptw_rsp_if.source                 rsp
);

    logic [ptw_pkg::PPN_W-1:0] root_ppn_reg;

    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic [31:0] s1_vaddr_reg;
    logic [31:0] s1_pte_reg;

    ptw_pkg::ptw_state_t  state_reg;
    ptw_pkg::ptw_state_t  state_next;
    ptw_pkg::ptw_result_t step_result;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_addr_reg;
    logic        out_code_reg;

    logic advance;
    logic req_take;

    // the held request moves on once the output slot can take its result
    assign advance  = s1_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready = ~s1_valid_reg | advance;
    assign req_take = req.valid & req.ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_ppn_reg <= '0;
        else if (cfg_wr_en)
            root_ppn_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_func_reg  <= req.func;
            s1_vaddr_reg <= req.virt_addr;
            s1_pte_reg   <= req.pte_word;
        end
    end

    // walk decode
    ptw_walk_step u_step (
        .func       (s1_func_reg),
        .virt_addr  (s1_vaddr_reg),
        .pte_word   (s1_pte_reg),
        .root_ppn   (root_ppn_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.busy  <= 1'b0;
            state_reg.level <= 1'b1;
            state_reg.vaddr <= '0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~rsp.ready;
        if (advance && step_result.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_result.emit)
        begin
            out_kind_reg <= step_result.kind;
            out_addr_reg <= step_result.phys_addr;
            out_code_reg <= step_result.fault_code;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.phys_addr  = out_addr_reg;
    assign rsp.fault_code = out_code_reg;

endmodule

// ----- tb/walk_checker.sv -----
`timescale 1ns / 100ps
// walk_checker: predicts every result of the two-level page table walker and compares
// depends on ptw_pkg, ptw_req_if and ptw_rsp_if; only watches the channels, drives nothing on them

module walk_checker
    import ptw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [PPN_W-1:0]   cfg_wr_data,
    ptw_req_if                 req,
    ptw_rsp_if                 rsp,
    output int unsigned        fail_count,
    output int unsigned        pending
);

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] phys_addr;
        logic              fault_code;
    } walk_result_t;

    // walker copy: root table, walk in flight, level, latched virtual address
    logic [PPN_W-1:0]  root_ppn;
    logic              walk_busy;
    logic              walk_level;
    logic [ADDR_W-1:0] walk_vaddr;

    walk_result_t expected_walk_results[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // advance the walker copy by one request, queue the result it gives
    function automatic void predict_walk_step(input logic func, input logic [31:0] vaddr,
                                              input logic [31:0] pte);
        logic [PPN_W-1:0] pte_ppn;
        logic [9:0]       vpn0;
        logic [11:0]      page_off;
        walk_result_t     res;
        pte_ppn  = pte[31:10];
        vpn0     = walk_vaddr[21:12];
        page_off = walk_vaddr[11:0];
        res      = '0;
        if (func == FUNC_TRANSLATE)
        begin
            if (walk_busy)
                return;
            walk_vaddr = vaddr;
            walk_busy  = 1'b1;
            walk_level = 1'b1;
            // level-1 entry address, upper root bits fall off the 32-bit address
            res.kind       = KIND_READ;
            res.phys_addr  = {root_ppn[19:0], vaddr[31:22], 2'b00};
            res.fault_code = FAULT_INVALID;
            expected_walk_results.push_back(res);
            return;
        end
        // entry word while idle is dropped
        if (!walk_busy)
            return;
        if (!pte[0])
        begin
            walk_busy      = 1'b0;
            walk_level     = 1'b1;
            res.kind       = KIND_FAULT;
            res.phys_addr  = '0;
            res.fault_code = FAULT_INVALID;
        end
        else if (pte[1] || pte[3])
        begin
            // leaf: superpage at level 1, 4 KiB page at level 0
            if (walk_level)
                res.phys_addr = {pte_ppn[19:10], vpn0, page_off};
            else
                res.phys_addr = {pte_ppn[19:0], page_off};
            walk_busy      = 1'b0;
            walk_level     = 1'b1;
            res.kind       = KIND_DONE;
            res.fault_code = FAULT_INVALID;
        end
        else if (walk_level)
        begin
            walk_level     = 1'b0;
            res.kind       = KIND_READ;
            res.phys_addr  = {pte_ppn[19:0], vpn0, 2'b00};
            res.fault_code = FAULT_INVALID;
        end
        else
        begin
            // pointer found at the last level
            walk_busy      = 1'b0;
            walk_level     = 1'b1;
            res.kind       = KIND_FAULT;
            res.phys_addr  = '0;
            res.fault_code = FAULT_DEEP;
        end
        expected_walk_results.push_back(res);
    endfunction

    // compare results, track config writes, predict accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        if (!rst_n)
        begin
            root_ppn   = '0;
            walk_busy  = 1'b0;
            walk_level = 1'b1;
            walk_vaddr = '0;
            expected_walk_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_walk_results.size() == 0)
                begin
                    $error("result with none pending: kind %0d phys_addr %h fault_code %0d",
                           rsp.kind, rsp.phys_addr, rsp.fault_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_walk_results.pop_front();
                    if (rsp.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
                        fail_count++;
                    end
                    if (rsp.phys_addr !== want.phys_addr)
                    begin
                        $error("phys_addr: expected %h, actual %h", want.phys_addr,
                               rsp.phys_addr);
                        fail_count++;
                    end
                    if (rsp.fault_code !== want.fault_code)
                    begin
                        $error("fault_code: expected %0d, actual %0d", want.fault_code,
                               rsp.fault_code);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
                root_ppn = cfg_wr_data;
            if (req.valid && req.ready)
                predict_walk_step(req.func, req.virt_addr, req.pte_word);
        end
        pending = expected_walk_results.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// tb: stimulus and verdict for the two-level page table walker
// depends on ptw_pkg, ptw_req_if, ptw_rsp_if, walk_checker and the walker itself

module tb;
    import ptw_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned PHASE_ITEMS   = 150;

    typedef enum {PTE_INVALID, PTE_LEAF, PTE_POINTER} pte_shape_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [PPN_W-1:0] cfg_wr_data;
    int unsigned      fail_count;
    int unsigned      pending;

    // sender burst state
    int unsigned      burst_left;
    logic             valid_up;

    ptw_req_if req_ch ();
    ptw_rsp_if rsp_ch ();

    two_level_page_table_walker i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    walk_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stall patterns plus a long hold every so often
    initial
    begin
        int unsigned rx_cycle;
        int unsigned hold_at;
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        rx_cycle  = 0;
        hold_at   = 150;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle == hold_at)
            begin
                hold_left = 80;
                hold_at   = hold_at + 1100;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 40);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // offer one request in the current burst, open a gap when the burst runs out
    task automatic offer(input logic func, input logic [31:0] vaddr, input logic [31:0] pte);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0 && valid_up)
            begin
                req_ch.valid <= 1'b0;
                valid_up = 1'b0;
            end
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= func;
        req_ch.virt_addr <= vaddr;
        req_ch.pte_word  <= pte;
        valid_up = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_translate(input logic [31:0] vaddr);
        offer(FUNC_TRANSLATE, vaddr, $urandom);
    endtask

    task automatic send_pte(input logic [31:0] pte);
        offer(FUNC_PTE_RESP, $urandom, pte);
    endtask

    // stop sending until every pending result is back and the pipe is empty
    task automatic drain();
        int unsigned waited;
        waited = 0;
        if (valid_up)
        begin
            req_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_root(input logic [PPN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // random root page number
    function automatic logic [PPN_W-1:0] rand_root();
        logic [31:0] r;
        r = $urandom;
        return r[PPN_W-1:0];
    endfunction

    function automatic pte_shape_t pick_shape();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return PTE_INVALID;
        if (r < 55)
            return PTE_LEAF;
        return PTE_POINTER;
    endfunction

    // random entry word with the flag bits forced to the wanted shape
    function automatic logic [31:0] make_pte(input pte_shape_t shape);
        logic [31:0] w;
        w = $urandom;
        case (shape)
            PTE_INVALID:
                w[0] = 1'b0;
            PTE_LEAF:
            begin
                w[0] = 1'b1;
                w[1] = ($urandom_range(0, 1) != 0);
                w[3] = w[1] ? ($urandom_range(0, 1) != 0) : 1'b1;
            end
            default:
            begin
                w[0] = 1'b1;
                w[1] = 1'b0;
                w[3] = 1'b0;
            end
        endcase
        return w;
    endfunction

    // one walk with random content, now and then broken or with stray requests
    task automatic random_walk(inout int unsigned counted);
        pte_shape_t shape;
        if ($urandom_range(0, 19) == 0)
            send_pte($urandom);
        send_translate($urandom);
        counted++;
        if ($urandom_range(0, 9) == 0)
            send_translate($urandom);
        if ($urandom_range(0, 19) == 0)
            return;
        shape = pick_shape();
        send_pte(make_pte(shape));
        counted++;
        if (shape == PTE_POINTER)
        begin
            if ($urandom_range(0, 9) == 0)
                send_translate($urandom);
            send_pte(make_pte(pick_shape()));
            counted++;
        end
    endtask

    task automatic random_phase(input logic [PPN_W-1:0] root);
        int unsigned counted;
        logic        paused;
        counted = 0;
        paused  = 1'b0;
        write_root(root);
        while (counted < PHASE_ITEMS)
        begin
            random_walk(counted);
            // one full pause in the middle of the phase
            if (!paused && counted >= PHASE_ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_TRANSLATE;
        req_ch.virt_addr = '0;
        req_ch.pte_word  = '0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        burst_left       = 0;
        valid_up         = 1'b0;
        rst_n            = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // root at zero: idle response, invalid entry, busy request, superpage
        write_root('0);
        send_pte(32'hFFFF_FFFF);
        send_translate(32'h0000_0000);
        send_pte(32'h0000_0000);
        send_translate(32'hFFFF_FFFF);
        send_translate(32'h1234_5678);
        send_pte(32'hFFFF_FFFF);
        drain();

        // root at max: address truncation, both levels, deep walk
        write_root({PPN_W{1'b1}});
        send_translate(32'h0000_0000);
        send_pte(32'hFFFF_FC01);
        send_pte(32'h0000_0003);
        send_translate(32'hFFFF_FFFF);
        // write-only entry is still a pointer
        send_pte(32'h0000_0005);
        send_pte(32'hFFFF_FC09);
        send_translate(32'hA5A5_A5A5);
        send_pte(32'h0000_0401);
        send_pte(32'hFFFF_FFF1);
        send_translate(32'h5A5A_5A5A);
        send_pte(32'h0000_0001);
        send_pte(32'hFFFF_FFFE);
        send_translate(32'h003F_F000);
        send_pte(32'h0000_000B);
        send_pte(32'h0000_0001);
        drain();

        // random walks under several roots
        random_phase(rand_root());
        random_phase(22'd1);
        random_phase({PPN_W{1'b1}});
        random_phase('0);
        random_phase(rand_root());

        if (pending != 0)
            $error("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
